### src/keyed_weighted_count_table_assert.svh
// Assertion macros shared by the keyed weighted count table RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef KEYED_WEIGHTED_COUNT_TABLE_ASSERT_SVH
`define KEYED_WEIGHTED_COUNT_TABLE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define KWCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KWCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kwct_pkg.sv
// Types and constants of the keyed weighted count table.
// No dependencies; used by every module of the block.
package kwct_pkg;

  localparam int VERSION_SLOTS = 16;
  localparam int DENOM_BITS    = 4;
  localparam int DENOMS        = 1 << DENOM_BITS;
  localparam int CTR_DEPTH     = VERSION_SLOTS * DENOMS;
  localparam int CTR_ADDR_W    = $clog2(CTR_DEPTH);
  localparam int SLOT_IDX_W    = (VERSION_SLOTS > 1) ? $clog2(VERSION_SLOTS) : 1;
  localparam int SLOT_CNT_W    = $clog2(VERSION_SLOTS + 1);
  localparam int WALK_W        = $clog2(CTR_DEPTH + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INC   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        key_version;
    logic signed [31:0] amount;
    logic               merge_version;
    logic               merge_denom;
  } kwct_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] total_value;
    logic [31:0] total_coins;
  } kwct_out_t;

  // Classified item handed from front to back.
  typedef struct packed {
    cmd_t                  command;
    logic [31:0]           version;
    logic [DENOM_BITS-1:0] denom;
    logic [31:0]           amount;
  } kwct_item_t;

endpackage

### src/keyed_weighted_count_table.sv
// The back end runs one item at a time: an increment finds or appends its version slot and
// then updates one counter, or goes straight to the response when the table is full and no
// slot matches; a query reads the counters of every used slot, one counter per cycle; clear
// or no-op go straight to the response; a two-entry queue takes further items meanwhile.
// Reset (rst_n low, synchronous): table empty, counters zero.
// Top level of the keyed weighted count table; depends on kwct_pkg, kwct_front, kwct_back.
module keyed_weighted_count_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kwct_pkg::kwct_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kwct_pkg::kwct_out_t out_data
);
  import kwct_pkg::*;

  logic       q_valid;
  logic       q_pop;
  kwct_item_t q_item;

  // Accept and classify
  kwct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Execute and answer
  kwct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### src/kwct_front.sv
// Front end: accepts input transfers, splits the key, queues classified items.
// Depends on kwct_pkg.
module kwct_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kwct_pkg::kwct_in_t  in_data,
  output logic                q_valid,
  output kwct_pkg::kwct_item_t q_item,
  input  logic                q_pop
);
  import kwct_pkg::*;

  kwct_item_t            q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;
  kwct_item_t            cls;
  logic                  push;
  logic                  pop;

  // Split the key into version and denomination, apply merge flags
  always_comb begin
    cls.command = cmd_t'(in_data.command);
    cls.version = in_data.merge_version ? 32'd0
                : {in_data.key_version[31:DENOM_BITS], {DENOM_BITS{1'b0}}};
    cls.denom   = in_data.merge_denom ? '0 : in_data.key_version[DENOM_BITS-1:0];
    cls.amount  = in_data.amount;
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### src/kwct_back.sv
// Back end: slot lookup, counter memory update, query walk, result register.
// Depends on kwct_pkg and keyed_weighted_count_table_assert.svh.
module kwct_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  kwct_pkg::kwct_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kwct_pkg::kwct_out_t  out_data
);
  import kwct_pkg::*;
  `include "keyed_weighted_count_table_assert.svh"

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MATCH  = 6'b000010,
    S_ADD    = 6'b000100,
    S_QRY    = 6'b001000,
    S_QDRAIN = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  kwct_item_t            cur_r;
  logic [31:0]           slot_version_r [VERSION_SLOTS];
  logic [SLOT_CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [31:0]           ctr_mem [CTR_DEPTH];
  logic [CTR_DEPTH-1:0]  ctr_vld_r;
  logic [31:0]           rd_data_r;
  logic                  rd_vld_r;
  logic [CTR_ADDR_W-1:0] rd_addr;
  logic [CTR_ADDR_W-1:0] addr_r;
  logic [WALK_W-1:0]     walk_r, walk_nxt;
  logic [WALK_W-1:0]     walk_end;
  logic                  acc_en_r, acc_en_nxt;
  logic [DENOM_BITS-1:0] acc_den_r;
  logic [31:0]           coins_r, coins_nxt;
  logic [31:0]           value_r, value_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kwct_out_t             out_data_r;
  logic [31:0]           ctr_val;
  logic [VERSION_SLOTS-1:0] hit_vec;
  logic                  hit_any;
  logic [SLOT_IDX_W-1:0] hit_idx;
  logic                  slot_append;
  logic                  wr_en;
  logic                  table_clear;
  logic                  out_load;

  // Compare the version against every used slot, take the lowest hit
  always_comb begin
    hit_idx = '0;
    for (int i = VERSION_SLOTS - 1; i >= 0; i--) begin
      hit_vec[i] = (SLOT_CNT_W'(i) < slots_used_r) && (slot_version_r[i] == cur_r.version);
      if (hit_vec[i]) begin
        hit_idx = SLOT_IDX_W'(i);
      end
    end
    hit_any = |hit_vec;
  end

  assign walk_end = WALK_W'({slots_used_r, {DENOM_BITS{1'b0}}});
  assign ctr_val  = rd_vld_r ? rd_data_r : 32'd0;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // Sequence one item at a time
  always_comb begin
    state_nxt      = state_r;
    slots_used_nxt = slots_used_r;
    walk_nxt       = walk_r;
    acc_en_nxt     = 1'b0;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    slot_append    = 1'b0;
    wr_en          = 1'b0;
    table_clear    = 1'b0;
    rd_addr        = addr_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          res_status_nxt = 1'b0;
          walk_nxt       = '0;
          case (q_item.command)
            CMD_INC:   state_nxt = S_MATCH;
            CMD_QUERY: state_nxt = S_QRY;
            CMD_CLEAR: begin
              table_clear    = 1'b1;
              slots_used_nxt = '0;
              state_nxt      = S_RESP;
            end
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_MATCH: begin
        if (hit_any) begin
          rd_addr   = {hit_idx, cur_r.denom};
          state_nxt = S_ADD;
        end else if (slots_used_r < SLOT_CNT_W'(VERSION_SLOTS)) begin
          slot_append    = 1'b1;
          slots_used_nxt = slots_used_r + 1'b1;
          rd_addr        = {slots_used_r[SLOT_IDX_W-1:0], cur_r.denom};
          state_nxt      = S_ADD;
        end else begin
          res_status_nxt = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_ADD: begin
        wr_en     = 1'b1;
        state_nxt = S_RESP;
      end
      S_QRY: begin
        if (walk_r < walk_end) begin
          rd_addr    = walk_r[CTR_ADDR_W-1:0];
          acc_en_nxt = 1'b1;
          walk_nxt   = walk_r + 1'b1;
        end else begin
          state_nxt = S_QDRAIN;
        end
      end
      S_QDRAIN: state_nxt = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Accumulate the query sums one counter per cycle
  always_comb begin
    coins_nxt = coins_r;
    value_nxt = value_r;
    if ((state_r == S_IDLE) && q_valid) begin
      coins_nxt = '0;
      value_nxt = '0;
    end else if (acc_en_r) begin
      coins_nxt = coins_r + ctr_val;
      value_nxt = value_r + (ctr_val << acc_den_r);
    end
  end

  // Hold the result until the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= '0;
      ctr_vld_r    <= '0;
      acc_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      res_status_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      acc_en_r     <= acc_en_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      if (table_clear) begin
        ctr_vld_r <= '0;
      end else if (wr_en) begin
        ctr_vld_r[addr_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (slot_append) begin
      slot_version_r[slots_used_r[SLOT_IDX_W-1:0]] <= cur_r.version;
    end
    addr_r    <= rd_addr;
    acc_den_r <= rd_addr[DENOM_BITS-1:0];
    walk_r    <= walk_nxt;
    coins_r   <= coins_nxt;
    value_r   <= value_nxt;
    if (out_load) begin
      out_data_r.status      <= res_status_r;
      out_data_r.total_value <= (cur_r.command == CMD_QUERY) ? value_r : 32'd0;
      out_data_r.total_coins <= (cur_r.command == CMD_QUERY) ? coins_r : 32'd0;
    end
  end

  // Counter memory: one read, one write port, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= ctr_mem[rd_addr];
    rd_vld_r  <= ctr_vld_r[rd_addr];
    if (wr_en) begin
      ctr_mem[addr_r] <= ctr_val + cur_r.amount;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KWCT_ASSERT_SAME(a_slots_bound, 1'b1, slots_used_r <= SLOT_CNT_W'(VERSION_SLOTS), "slot count overflow")
  `KWCT_ASSERT_NEXT(a_clear_empties, (state_r == S_IDLE) && q_valid && (q_item.command == CMD_CLEAR), (slots_used_r == '0) && (ctr_vld_r == '0), "clear left table state")
  `KWCT_ASSERT_SAME(a_full_status, out_load && res_status_r, slots_used_r == SLOT_CNT_W'(VERSION_SLOTS), "full status with free slots")
  `KWCT_ASSERT_SAME(a_acc_in_query, acc_en_r, (state_r == S_QRY) || (state_r == S_QDRAIN), "accumulate outside query")

endmodule
